[rtl/smac_pkg.sv]
// package for the simd multiply-accumulate unit: request/response structs, opcodes
// no dependencies
`timescale 1ns / 1ps
package smac_pkg;
   localparam int unsigned WordBits = 32;
   localparam int unsigned HalfLanes = 8;
   localparam int unsigned WordLanes = 2;

   localparam logic [3:0] OP_MADD    = 4'd0;
   localparam logic [3:0] OP_MADDU   = 4'd1;
   localparam logic [3:0] OP_PHMADH  = 4'd2;
   localparam logic [3:0] OP_PHMSBH  = 4'd3;
   localparam logic [3:0] OP_PMADDH  = 4'd4;
   localparam logic [3:0] OP_PMSUBH  = 4'd5;
   localparam logic [3:0] OP_PMADDW  = 4'd6;
   localparam logic [3:0] OP_PMSUBW  = 4'd7;
   localparam logic [3:0] OP_PMADDUW = 4'd8;

   typedef struct packed {
      logic [3:0]  operation;
      logic [63:0] rs_low;
      logic [63:0] rs_high;
      logic [63:0] rt_low;
      logic [63:0] rt_high;
   } req_type;

   typedef struct packed {
      logic [63:0] rd_low;
      logic [63:0] rd_high;
      logic        rd_high_written;
      logic [63:0] lo_low_out;
      logic [63:0] lo_high_out;
      logic [63:0] hi_low_out;
      logic [63:0] hi_high_out;
   } rsp_type;

   // decoded operation flags carried with the lane products
   typedef struct packed {
      logic word_op;   // madd, maddu, pmaddw, pmsubw, pmadduw
      logic dual_word; // two word lanes
      logic sub;
      logic half_pair; // phmadh / phmsbh
      logic half_acc;  // pmaddh / pmsubh
      logic valid_op;
   } ctl_type;
endpackage

[rtl/smac_lanes.sv]
// product stage: eight 16x16 signed lanes and two 33x33 word lanes, registered
// depends on smac_pkg
`timescale 1ns / 1ps
module smac_lanes (
   input  logic                 clock,
   input  logic                 advance,
   input  smac_pkg::req_type    req,
   output smac_pkg::ctl_type    ctl_ff,
   output logic [31:0]          hprod_ff [smac_pkg::HalfLanes],
   output logic [63:0]          wprod_ff [smac_pkg::WordLanes]
);
   logic [127:0] rs, rt;
   smac_pkg::ctl_type ctl_in;
   logic sgn;

   assign rs = {req.rs_high, req.rs_low};
   assign rt = {req.rt_high, req.rt_low};

   always_comb begin
      ctl_in = '0;
      sgn = 1'b0;
      unique case (req.operation)
         smac_pkg::OP_MADD: begin ctl_in.word_op = 1'b1; sgn = 1'b1; end
         smac_pkg::OP_MADDU: ctl_in.word_op = 1'b1;
         smac_pkg::OP_PHMADH: ctl_in.half_pair = 1'b1;
         smac_pkg::OP_PHMSBH: begin ctl_in.half_pair = 1'b1; ctl_in.sub = 1'b1; end
         smac_pkg::OP_PMADDH: ctl_in.half_acc = 1'b1;
         smac_pkg::OP_PMSUBH: begin ctl_in.half_acc = 1'b1; ctl_in.sub = 1'b1; end
         smac_pkg::OP_PMADDW: begin
            ctl_in.word_op = 1'b1; ctl_in.dual_word = 1'b1; sgn = 1'b1;
         end
         smac_pkg::OP_PMSUBW: begin
            ctl_in.word_op = 1'b1; ctl_in.dual_word = 1'b1; sgn = 1'b1; ctl_in.sub = 1'b1;
         end
         smac_pkg::OP_PMADDUW: begin ctl_in.word_op = 1'b1; ctl_in.dual_word = 1'b1; end
         default: ;
      endcase
      ctl_in.valid_op = ctl_in.word_op | ctl_in.half_pair | ctl_in.half_acc;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff <= ctl_in;
         for (int i = 0; i < smac_pkg::HalfLanes; i++) begin
            hprod_ff[i] <= 32'($signed(rs[16*i +: 16]) * $signed(rt[16*i +: 16]));
         end
         for (int k = 0; k < smac_pkg::WordLanes; k++) begin
            // extend by one bit so one signed multiplier serves both signednesses
            wprod_ff[k] <= 64'($signed({sgn & rs[64*k+31], rs[64*k +: 32]})
                              * $signed({sgn & rt[64*k+31], rt[64*k +: 32]}));
         end
      end
   end
endmodule

[rtl/smac_merge.sv]
// merge stage: applies lane products to the hi/lo accumulators and forms rd
// depends on smac_pkg
`timescale 1ns / 1ps
module smac_merge (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  smac_pkg::ctl_type  ctl,
   input  logic [31:0]        hprod [smac_pkg::HalfLanes],
   input  logic [63:0]        wprod [smac_pkg::WordLanes],
   output smac_pkg::rsp_type  rsp_in
);
   logic [127:0] lo_ff, hi_ff, lo_in, hi_in;
   logic [127:0] rd;
   logic [63:0]  acc [smac_pkg::WordLanes];
   logic [31:0]  r;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      rd = '0;
      r = '0;
      for (int k = 0; k < smac_pkg::WordLanes; k++) begin
         acc[k] = {hi_ff[64*k +: 32], lo_ff[64*k +: 32]};
         acc[k] = ctl.sub ? acc[k] - wprod[k] : acc[k] + wprod[k];
      end
      if (ctl.word_op) begin
         for (int k = 0; k < smac_pkg::WordLanes; k++) begin
            if (k == 0 || ctl.dual_word) begin
               lo_in[64*k +: 64] = {{32{acc[k][31]}}, acc[k][31:0]};
               hi_in[64*k +: 64] = {{32{acc[k][63]}}, acc[k][63:32]};
               rd[64*k +: 64] = ctl.dual_word ? acc[k] : {{32{acc[k][31]}}, acc[k][31:0]};
            end
         end
      end else if (ctl.half_pair) begin
         for (int k = 0; k < 4; k++) begin
            r = ctl.sub ? hprod[2*k+1] - hprod[2*k] : hprod[2*k+1] + hprod[2*k];
            rd[32*k +: 32] = r;
            if (k[0]) hi_in[64*(k>>1) +: 32] = r;
            else      lo_in[64*(k>>1) +: 32] = r;
         end
      end else if (ctl.half_acc) begin
         for (int i = 0; i < smac_pkg::HalfLanes; i++) begin
            // halfword i maps to word ((i>>2)<<1)|(i&1) of hi or lo
            if (i[1]) begin
               r = ctl.sub ? hi_ff[32*(((i>>2)<<1)|(i&1)) +: 32] - hprod[i]
                           : hi_ff[32*(((i>>2)<<1)|(i&1)) +: 32] + hprod[i];
               hi_in[32*(((i>>2)<<1)|(i&1)) +: 32] = r;
            end else begin
               r = ctl.sub ? lo_ff[32*(((i>>2)<<1)|(i&1)) +: 32] - hprod[i]
                           : lo_ff[32*(((i>>2)<<1)|(i&1)) +: 32] + hprod[i];
               lo_in[32*(((i>>2)<<1)|(i&1)) +: 32] = r;
            end
            if (!i[0]) rd[32*(i>>1) +: 32] = r;
         end
      end
      rsp_in.rd_low = rd[63:0];
      rsp_in.rd_high_written = ctl.valid_op & ~(ctl.word_op & ~ctl.dual_word);
      rsp_in.rd_high = rsp_in.rd_high_written ? rd[127:64] : 64'd0;
      rsp_in.lo_low_out = lo_in[63:0];
      rsp_in.lo_high_out = lo_in[127:64];
      rsp_in.hi_low_out = hi_in[63:0];
      rsp_in.hi_high_out = hi_in[127:64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else if (fire) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end
endmodule

[rtl/simd_multiply_accumulate_hilo.sv]
// channel   | ports          | payload
// request   | req_valid/ready| smac_pkg::req_type
// response  | rsp_valid/ready| smac_pkg::rsp_type
// two stages: lane products, then accumulate merge into an output register.
// one request per cycle when not stalled; the accumulate add is the feedback loop.
// reset clears hi/lo and the stage valids. a stalled response holds the pipe.
`timescale 1ns / 1ps
module simd_multiply_accumulate_hilo (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  smac_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output smac_pkg::rsp_type  rsp_payload
);
   logic s1_valid_ff, rsp_valid_ff;
   logic out_free, s1_free;
   smac_pkg::ctl_type ctl;
   logic [31:0] hprod [smac_pkg::HalfLanes];
   logic [63:0] wprod [smac_pkg::WordLanes];
   smac_pkg::rsp_type rsp_in, rsp_ff;

   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign s1_free = ~s1_valid_ff | out_free;
   assign req_ready = s1_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   smac_lanes u_lanes (
      .clock(clock), .advance(req_valid & s1_free), .req(req_payload),
      .ctl_ff(ctl), .hprod_ff(hprod), .wprod_ff(wprod)
   );

   smac_merge u_merge (
      .clock(clock), .reset(reset), .fire(s1_valid_ff & out_free),
      .ctl(ctl), .hprod(hprod), .wprod(wprod), .rsp_in(rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) s1_valid_ff <= req_valid;
         if (out_free) rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff & out_free) rsp_ff <= rsp_in;
   end
endmodule
